// ----- rtl/tcw_pkg.sv -----
// Shared constants, types and helpers of the text console writer.
package tcw_pkg;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int CELLS     = ROWS * COLUMNS;

  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_IDX_W = $clog2(COLUMNS);
  localparam int CCOL_W    = $clog2(COLUMNS + 1);
  localparam int ADDR_W    = $clog2(CELLS);

  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int CELL_W    = CHAR_W + ATTR_W;
  localparam int RROW_W    = 5;
  localparam int RCOL_W    = 7;
  localparam int OROW_W    = 5;
  localparam int OCOL_W    = 7;

  localparam logic [CHAR_W-1:0] BLANK_CODE = 8'h20;
  localparam logic [ATTR_W-1:0] CLEAR_ATTR = 8'h0F;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd15;

  localparam logic [CHAR_W-1:0] CH_NUL = 8'd0;
  localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL  = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

  localparam int TAB_STEP   = 4;
  localparam int ODD_BS_COL = 8;
  localparam int BS_ODD_NEXT  = (ODD_BS_COL + 1 > COLUMNS) ? COLUMNS : ODD_BS_COL + 1;
  localparam bit BS_ODD_WRITE = (ODD_BS_COL + 1 < COLUMNS);

  typedef enum logic [2:0] {
    CC_NUL,
    CC_NL,
    CC_CR,
    CC_BS,
    CC_TAB,
    CC_PRINT
  } chr_class_e;

  typedef struct packed {
    logic load;
    logic clr;
    logic nl;
    logic scroll;
    logic cr;
    logic bs;
    logic tab;
    logic prnt;
    logic rd;
    logic out;
  } dp_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       is_read;
    chr_class_e ch_class;
    logic       col_full;
    logic       line_last;
    logic       scroll_last;
    logic       tab_last;
  } dp_status_t;

  function automatic chr_class_e classify(input logic [CHAR_W-1:0] ch);
    chr_class_e c;
    case (ch)
      CH_NUL:  c = CC_NUL;
      CH_NL:   c = CC_NL;
      CH_CR:   c = CC_CR;
      CH_BS:   c = CC_BS;
      CH_TAB:  c = CC_TAB;
      default: c = CC_PRINT;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/tcw_if.sv -----
// Valid/ready channel interfaces for input words and result words.
interface tcw_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [tcw_pkg::CHAR_W-1:0]    character;
  logic [tcw_pkg::RROW_W-1:0]    read_row;
  logic [tcw_pkg::RCOL_W-1:0]    read_column;

  modport source(output valid, operation, character, read_row, read_column, input ready);
  modport sink(input valid, operation, character, read_row, read_column, output ready);
endinterface

interface tcw_out_if;
  logic                          valid;
  logic                          ready;
  logic [tcw_pkg::CHAR_W-1:0]    cell_character;
  logic [tcw_pkg::ATTR_W-1:0]    cell_attribute;
  logic [tcw_pkg::OROW_W-1:0]    cursor_row;
  logic [tcw_pkg::OCOL_W-1:0]    cursor_column;

  modport source(output valid, cell_character, cell_attribute, cursor_row, cursor_column,
                 input ready);
  modport sink(input valid, cell_character, cell_attribute, cursor_row, cursor_column,
               output ready);
endinterface

// ----- rtl/tcw_ram.sv -----
// Generic simple dual-port RAM with registered read.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tcw_dp.sv -----
// Datapath: cursor, scroll base, attribute, screen store and result registers.
module tcw_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tcw_pkg::dp_cmd_t               cmd_i,
  output tcw_pkg::dp_status_t            status_o,
  input  logic                           operation_i,
  input  logic [tcw_pkg::CHAR_W-1:0]     character_i,
  input  logic [tcw_pkg::RROW_W-1:0]     read_row_i,
  input  logic [tcw_pkg::RCOL_W-1:0]     read_column_i,
  input  logic                           text_attribute_we_i,
  input  logic [tcw_pkg::ATTR_W-1:0]     text_attribute_i,
  output logic [tcw_pkg::CHAR_W-1:0]     cell_character_o,
  output logic [tcw_pkg::ATTR_W-1:0]     cell_attribute_o,
  output logic [tcw_pkg::OROW_W-1:0]     cursor_row_o,
  output logic [tcw_pkg::OCOL_W-1:0]     cursor_column_o
);

  localparam int ROW_W     = tcw_pkg::ROW_W;
  localparam int COL_IDX_W = tcw_pkg::COL_IDX_W;
  localparam int CCOL_W    = tcw_pkg::CCOL_W;
  localparam int ADDR_W    = tcw_pkg::ADDR_W;

  logic [ROW_W-1:0]              line_q, line_d;
  logic [CCOL_W-1:0]             col_q, col_d;
  logic [ROW_W-1:0]              base_q, base_d;
  logic [ADDR_W-1:0]             cnt_q, cnt_d;
  logic [tcw_pkg::ATTR_W-1:0]    attr_q;

  logic                          op_q;
  logic [tcw_pkg::CHAR_W-1:0]    ch_q;
  logic [tcw_pkg::RROW_W-1:0]    rd_row_q;
  logic [tcw_pkg::RCOL_W-1:0]    rd_col_q;

  logic [tcw_pkg::CHAR_W-1:0]    out_char_q;
  logic [tcw_pkg::ATTR_W-1:0]    out_attr_q;
  logic [tcw_pkg::OROW_W-1:0]    out_row_q;
  logic [tcw_pkg::OCOL_W-1:0]    out_col_q;

  logic [ROW_W-1:0]              row_sel;
  logic [COL_IDX_W-1:0]          col_sel;
  logic [tcw_pkg::CHAR_W-1:0]    wchar;
  logic                          ram_we;
  logic                          direct;
  logic [ROW_W:0]                row_sum;
  logic [ROW_W-1:0]              phys_row;
  logic [ADDR_W-1:0]             addr;
  logic [tcw_pkg::CELL_W-1:0]    wdata;
  logic [tcw_pkg::CELL_W-1:0]    rdata;
  logic                          rd_ok;
  logic [CCOL_W-1:0]             col_inc;
  logic                          clr_last;
  logic                          line_last;

  assign clr_last  = (cnt_q == ADDR_W'(tcw_pkg::CELLS - 1));
  assign line_last = (line_q == ROW_W'(tcw_pkg::ROWS - 1));
  assign col_inc   = col_q + 1'b1;
  assign rd_ok     = (int'(rd_row_q) < tcw_pkg::ROWS) && (int'(rd_col_q) < tcw_pkg::COLUMNS);

  always_comb begin
    row_sel = line_q;
    col_sel = COL_IDX_W'(col_q);
    wchar   = tcw_pkg::BLANK_CODE;
    ram_we  = 1'b0;
    direct  = 1'b0;
    line_d  = line_q;
    col_d   = col_q;
    base_d  = base_q;
    cnt_d   = cnt_q;
    if (cmd_i.clr) begin
      ram_we = 1'b1;
      direct = 1'b1;
      cnt_d  = clr_last ? '0 : cnt_q + 1'b1;
    end
    if (cmd_i.nl) begin
      col_d = '0;
      cnt_d = '0;
      if (line_last) begin
        base_d = (base_q == ROW_W'(tcw_pkg::ROWS - 1)) ? '0 : base_q + 1'b1;
      end else begin
        line_d = line_q + 1'b1;
      end
    end
    if (cmd_i.scroll) begin
      ram_we  = 1'b1;
      row_sel = ROW_W'(tcw_pkg::ROWS - 1);
      col_sel = cnt_q[COL_IDX_W-1:0];
      cnt_d   = cnt_q + 1'b1;
    end
    if (cmd_i.cr) begin
      col_d = '0;
    end
    if (cmd_i.bs) begin
      if (col_q == CCOL_W'(tcw_pkg::ODD_BS_COL)) begin
        col_d   = CCOL_W'(tcw_pkg::BS_ODD_NEXT);
        col_sel = COL_IDX_W'(tcw_pkg::ODD_BS_COL + 1);
        ram_we  = tcw_pkg::BS_ODD_WRITE;
      end else if (col_q == '0) begin
        if (line_q != '0) begin
          line_d  = line_q - 1'b1;
          col_d   = CCOL_W'(tcw_pkg::COLUMNS - 1);
          row_sel = line_q - 1'b1;
          col_sel = COL_IDX_W'(tcw_pkg::COLUMNS - 1);
          ram_we  = 1'b1;
        end
      end else begin
        col_d   = col_q - 1'b1;
        col_sel = COL_IDX_W'(col_q - 1'b1);
        ram_we  = 1'b1;
      end
    end
    if (cmd_i.tab) begin
      ram_we = 1'b1;
      col_d  = col_inc;
    end
    if (cmd_i.prnt) begin
      ram_we = 1'b1;
      wchar  = ch_q;
      col_d  = col_inc;
    end
    if (cmd_i.rd) begin
      row_sel = ROW_W'(rd_row_q);
      col_sel = COL_IDX_W'(rd_col_q);
    end
  end

  // Logical row to physical row through the rotating scroll base.
  assign row_sum  = (ROW_W + 1)'(row_sel) + (ROW_W + 1)'(base_q);
  assign phys_row = (row_sum >= (ROW_W + 1)'(tcw_pkg::ROWS)) ?
                    ROW_W'(row_sum - (ROW_W + 1)'(tcw_pkg::ROWS)) : ROW_W'(row_sum);
  assign addr     = direct ? cnt_q :
                    ADDR_W'(ADDR_W'(phys_row) * ADDR_W'(tcw_pkg::COLUMNS) + ADDR_W'(col_sel));
  assign wdata    = direct ? {tcw_pkg::CLEAR_ATTR, tcw_pkg::BLANK_CODE} : {attr_q, wchar};

  tcw_ram #(
    .WIDTH(tcw_pkg::CELL_W),
    .DEPTH(tcw_pkg::CELLS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(addr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd && rd_ok),
    .raddr_i(addr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0;
      col_q  <= '0;
      base_q <= '0;
      cnt_q  <= '0;
      attr_q <= tcw_pkg::ATTR_RESET;
    end else begin
      line_q <= line_d;
      col_q  <= col_d;
      base_q <= base_d;
      cnt_q  <= cnt_d;
      if (text_attribute_we_i) begin
        attr_q <= text_attribute_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= operation_i;
      ch_q     <= character_i;
      rd_row_q <= read_row_i;
      rd_col_q <= read_column_i;
    end
    if (cmd_i.out) begin
      out_char_q <= (op_q && rd_ok) ? rdata[tcw_pkg::CHAR_W-1:0] : '0;
      out_attr_q <= (op_q && rd_ok) ? rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W] : '0;
      out_row_q  <= tcw_pkg::OROW_W'(line_q);
      out_col_q  <= tcw_pkg::OCOL_W'(col_q);
    end
  end

  always_comb begin
    status_o.clr_last    = clr_last;
    status_o.is_read     = op_q;
    status_o.ch_class    = tcw_pkg::classify(ch_q);
    status_o.col_full    = (col_q >= CCOL_W'(tcw_pkg::COLUMNS));
    status_o.line_last   = line_last;
    status_o.scroll_last = (cnt_q[COL_IDX_W-1:0] == COL_IDX_W'(tcw_pkg::COLUMNS - 1));
    status_o.tab_last    = ((col_inc % CCOL_W'(tcw_pkg::TAB_STEP)) == '0) ||
                           (col_inc == CCOL_W'(tcw_pkg::COLUMNS));
  end

  assign cell_character_o = out_char_q;
  assign cell_attribute_o = out_attr_q;
  assign cursor_row_o     = out_row_q;
  assign cursor_column_o  = out_col_q;

endmodule

// ----- rtl/tcw_ctrl.sv -----
// Controller: sequences clear pass, put and read words, and the result handshake.
module tcw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  input  tcw_pkg::dp_status_t status_i,
  output tcw_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_NEWLINE,
    ST_SCROLL,
    ST_TAB,
    ST_PRINT,
    ST_READ,
    ST_FINISH
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  ctrl_state_e after_nl;
  logic        out_valid_q, out_valid_d;

  always_comb begin
    case (status_i.ch_class)
      tcw_pkg::CC_TAB:   after_nl = ST_TAB;
      tcw_pkg::CC_PRINT: after_nl = ST_PRINT;
      default:           after_nl = ST_FINISH;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (status_i.is_read) begin
          state_d = ST_READ;
        end else begin
          case (status_i.ch_class)
            tcw_pkg::CC_NUL: state_d = ST_FINISH;
            tcw_pkg::CC_CR: begin
              cmd_o.cr = 1'b1;
              state_d  = ST_FINISH;
            end
            tcw_pkg::CC_BS: begin
              cmd_o.bs = 1'b1;
              state_d  = ST_FINISH;
            end
            tcw_pkg::CC_NL:  state_d = ST_NEWLINE;
            tcw_pkg::CC_TAB: state_d = status_i.col_full ? ST_NEWLINE : ST_TAB;
            default:         state_d = status_i.col_full ? ST_NEWLINE : ST_PRINT;
          endcase
        end
      end
      ST_NEWLINE: begin
        cmd_o.nl = 1'b1;
        state_d  = status_i.line_last ? ST_SCROLL : after_nl;
      end
      ST_SCROLL: begin
        cmd_o.scroll = 1'b1;
        if (status_i.scroll_last) state_d = after_nl;
      end
      ST_TAB: begin
        cmd_o.tab = 1'b1;
        if (status_i.tab_last) state_d = ST_FINISH;
      end
      ST_PRINT: begin
        cmd_o.prnt = 1'b1;
        state_d    = ST_FINISH;
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/text_console_writer_core.sv -----
// Text console writer: character-cell screen store with cursor, top level.
// A word is taken only in idle; the next is taken once finish has registered the last result.
// Return, backspace and byte zero act in dispatch; newline, tab, print and read have own states.
// Newline on the last row blanks the bottom row with one store write per cell; tab writes
// one blank per padded cell (1 to 4). The single store write port serializes these writes.
// After reset ready stays low while the store (ROWS*COLUMNS = 2000 cells) is blanked.
module text_console_writer_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  tcw_in_if.sink                     item_i,
  tcw_out_if.source                  result_o,
  input  logic                       text_attribute_we_i,
  input  logic [tcw_pkg::ATTR_W-1:0] text_attribute_i
);

  tcw_pkg::dp_cmd_t    cmd;
  tcw_pkg::dp_status_t status;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .out_ready_i(result_o.ready),
    .out_valid_o(result_o.valid),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tcw_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .operation_i        (item_i.operation),
    .character_i        (item_i.character),
    .read_row_i         (item_i.read_row),
    .read_column_i      (item_i.read_column),
    .text_attribute_we_i(text_attribute_we_i),
    .text_attribute_i   (text_attribute_i),
    .cell_character_o   (result_o.cell_character),
    .cell_attribute_o   (result_o.cell_attribute),
    .cursor_row_o       (result_o.cursor_row),
    .cursor_column_o    (result_o.cursor_column)
  );

endmodule

// ----- rtl/tcw_checker.sv -----
// Port-level checker for the text console writer, bound to the top level.
module tcw_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [tcw_pkg::CHAR_W-1:0] cell_character_i,
  input logic [tcw_pkg::ATTR_W-1:0] cell_attribute_i,
  input logic [tcw_pkg::OROW_W-1:0] cursor_row_i,
  input logic [tcw_pkg::OCOL_W-1:0] cursor_column_i
);

  // result word holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(cell_character_i) &&
    $stable(cell_attribute_i) && $stable(cursor_row_i) && $stable(cursor_column_i))
    else $error("result word changed while stalled");

  // one word at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while a word is in work");

  // store clear pass blocks input right after reset
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !in_ready_i)
    else $error("input ready during store clear");

  // cursor row stays on screen, cursor column at most COLUMNS
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (int'(cursor_row_i) < tcw_pkg::ROWS) &&
    (int'(cursor_column_i) <= tcw_pkg::COLUMNS))
    else $error("cursor out of range");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (item_i.valid),
  .in_ready_i      (item_i.ready),
  .out_valid_i     (result_o.valid),
  .out_ready_i     (result_o.ready),
  .cell_character_i(result_o.cell_character),
  .cell_attribute_i(result_o.cell_attribute),
  .cursor_row_i    (result_o.cursor_row),
  .cursor_column_i (result_o.cursor_column)
);
